>>> hw/rtl/prqs_pkg.sv
// Package with shared codes and default sizes for the priority ready queue scheduler.
package prqs_pkg;

   // Default sizes.
   localparam int unsigned MAX_THREADS_DEF   = 16;
   localparam int unsigned PRIORITY_BITS_DEF = 8;
   localparam int unsigned ID_BITS_DEF       = 16;

   // Operation codes.
   localparam logic [2:0] ACT_ADD      = 3'd0;
   localparam logic [2:0] ACT_DELETE   = 3'd1;
   localparam logic [2:0] ACT_REQUEUE  = 3'd2;
   localparam logic [2:0] ACT_SETSTATE = 3'd3;
   localparam logic [2:0] ACT_SCHEDULE = 3'd4;

   // Thread state codes.
   localparam logic [2:0] THR_READY     = 3'd0;
   localparam logic [2:0] THR_RUNNING   = 3'd1;
   localparam logic [2:0] THR_JOIN_WAIT = 3'd2;
   localparam logic [2:0] THR_EXITED    = 3'd3;

   // Result status codes.
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

endpackage

>>> hw/rtl/prqs_table.sv
// Ordered thread table with one combinational read port and one write port.
module prqs_table #(
   parameter int unsigned MAX_THREADS   = prqs_pkg::MAX_THREADS_DEF,
   parameter int unsigned PRIORITY_BITS = prqs_pkg::PRIORITY_BITS_DEF,
   parameter int unsigned ID_BITS       = prqs_pkg::ID_BITS_DEF,
   localparam int unsigned IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  logic [ID_BITS-1:0]       wr_id,
   input  logic [PRIORITY_BITS-1:0] wr_prio,
   input  logic [2:0]               wr_state,
   input  logic [ID_BITS-1:0]       wr_join,
   input  logic [IW-1:0]            rd_addr,
   output logic [ID_BITS-1:0]       rd_id,
   output logic [PRIORITY_BITS-1:0] rd_prio,
   output logic [2:0]               rd_state,
   output logic [ID_BITS-1:0]       rd_join
);

   logic [ID_BITS-1:0]       id_ff    [MAX_THREADS];
   logic [PRIORITY_BITS-1:0] prio_ff  [MAX_THREADS];
   logic [2:0]               state_ff [MAX_THREADS];
   logic [ID_BITS-1:0]       join_ff  [MAX_THREADS];

   // One entry is written per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_ff[wr_addr]    <= wr_id;
         prio_ff[wr_addr]  <= wr_prio;
         state_ff[wr_addr] <= wr_state;
         join_ff[wr_addr]  <= wr_join;
      end
   end

   // The sequencer reads one entry per cycle.
   assign rd_id    = id_ff[rd_addr];
   assign rd_prio  = prio_ff[rd_addr];
   assign rd_state = state_ff[rd_addr];
   assign rd_join  = join_ff[rd_addr];

endmodule

>>> hw/rtl/priority_ready_queue_scheduler.sv
// Top level: sequencer that walks and shifts the ordered thread table one entry per cycle.
// Add, delete, set state and requeue walk the table; schedule also starts a scan for the
// target of each join waiter it meets. Full-table, empty-table and unknown-action commands
// are answered without going busy; one command is taken at a time.
// rsp_valid is high for one cycle right after the last busy cycle; the receiver cannot stall.
// Synchronous active-high reset empties the table, clears the running thread and srp_enable.
module priority_ready_queue_scheduler #(
   parameter int unsigned MAX_THREADS   = prqs_pkg::MAX_THREADS_DEF,
   parameter int unsigned PRIORITY_BITS = prqs_pkg::PRIORITY_BITS_DEF,
   parameter int unsigned ID_BITS       = prqs_pkg::ID_BITS_DEF,
   localparam int unsigned CW = $clog2(MAX_THREADS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic signed [ID_BITS-1:0] req_thread_id,
   input  logic [PRIORITY_BITS-1:0]  req_priority_req,
   input  logic [2:0]                req_new_state,
   input  logic signed [ID_BITS-1:0] req_join_target_id,
   input  logic [PRIORITY_BITS:0]    req_system_ceiling,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic                      rsp_switched,
   output logic                      rsp_running_valid,
   output logic signed [ID_BITS-1:0] rsp_running_id,
   output logic [CW-1:0]             rsp_thread_count
);

   localparam int unsigned IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_POS, S_SHUP, S_FIND, S_SHDN, S_WALK, S_JSRCH, S_REL,
      S_CSRCH, S_CCHK, S_DEMOTE, S_SWITCH
   } seq_state_type;

   seq_state_type            st_ff, st_in;
   logic [2:0]               op_ff, op_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [2:0]               nst_ff, nst_in;
   logic [ID_BITS-1:0]       jt_ff, jt_in;
   logic [PRIORITY_BITS:0]   ceil_ff, ceil_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            aux_ff, aux_in;
   logic [CW-1:0]            pick_ff, pick_in;
   logic                     srp_ff, srp_in;
   logic                     cur_valid_ff, cur_valid_in;
   logic [ID_BITS-1:0]       cur_id_ff, cur_id_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic                     switched_ff, switched_in;

   logic                     wr_en;
   logic [IW-1:0]            wr_addr, rd_addr;
   logic [ID_BITS-1:0]       wr_id, rd_id;
   logic [PRIORITY_BITS-1:0] wr_prio, rd_prio;
   logic [2:0]               wr_state, rd_state;
   logic [ID_BITS-1:0]       wr_join, rd_join;
   logic                     accept;

   prqs_table #(
      .MAX_THREADS(MAX_THREADS), .PRIORITY_BITS(PRIORITY_BITS), .ID_BITS(ID_BITS)
   ) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_id(wr_id), .wr_prio(wr_prio),
      .wr_state(wr_state), .wr_join(wr_join), .rd_addr(rd_addr), .rd_id(rd_id),
      .rd_prio(rd_prio), .rd_state(rd_state), .rd_join(rd_join)
   );

   assign busy   = (st_ff != S_IDLE);
   assign accept = start && !busy;

   // Sequencer next-state logic; every step reads at most one table entry.
   always_comb begin
      st_in = st_ff;  op_in = op_ff;  id_in = id_ff;  prio_in = prio_ff;
      nst_in = nst_ff;  jt_in = jt_ff;  ceil_in = ceil_ff;  cnt_in = cnt_ff;
      idx_in = idx_ff;  aux_in = aux_ff;  pick_in = pick_ff;
      srp_in = csr_wr_en ? csr_wr_data : srp_ff;
      cur_valid_in = cur_valid_ff;  cur_id_in = cur_id_ff;
      rsp_valid_in = 1'b0;  status_in = status_ff;  switched_in = switched_ff;
      wr_en = 1'b0;  wr_addr = idx_ff[IW-1:0];  rd_addr = idx_ff[IW-1:0];
      wr_id = rd_id;  wr_prio = rd_prio;  wr_state = rd_state;  wr_join = rd_join;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_action;  id_in = $unsigned(req_thread_id);
               prio_in = req_priority_req;  nst_in = req_new_state;
               jt_in = $unsigned(req_join_target_id);  ceil_in = req_system_ceiling;
               idx_in = '0;  status_in = prqs_pkg::STAT_DONE;  switched_in = 1'b0;
               case (req_action)
                  prqs_pkg::ACT_ADD: begin
                     if (cnt_ff == CW'(MAX_THREADS)) begin
                        status_in = prqs_pkg::STAT_FULL;  rsp_valid_in = 1'b1;
                     end else begin
                        st_in = S_POS;
                     end
                  end
                  prqs_pkg::ACT_DELETE, prqs_pkg::ACT_REQUEUE, prqs_pkg::ACT_SETSTATE: begin
                     if (cnt_ff == '0) begin
                        status_in = prqs_pkg::STAT_NOT_FOUND;  rsp_valid_in = 1'b1;
                     end else begin
                        st_in = S_FIND;
                     end
                  end
                  prqs_pkg::ACT_SCHEDULE: begin
                     if (cnt_ff == '0) begin
                        status_in = prqs_pkg::STAT_NOT_FOUND;  rsp_valid_in = 1'b1;
                     end else begin
                        st_in = S_WALK;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         // Find the first entry that is less urgent than the new one.
         S_POS: begin
            if (idx_ff == cnt_ff || rd_prio > prio_ff) begin
               pick_in = idx_ff;  idx_in = cnt_ff;  st_in = S_SHUP;
            end else begin
               idx_in = CW'(idx_ff + CW'(1));
            end
         end
         // Open a gap by moving entries up one place, then write the new entry.
         S_SHUP: begin
            wr_en = 1'b1;
            if (idx_ff == pick_ff) begin
               wr_id = id_ff;  wr_prio = prio_ff;  wr_state = nst_ff;  wr_join = jt_ff;
               cnt_in = CW'(cnt_ff + CW'(1));
               rsp_valid_in = 1'b1;  st_in = S_IDLE;
            end else begin
               rd_addr = IW'(idx_ff - CW'(1));
               idx_in = CW'(idx_ff - CW'(1));
            end
         end
         // Look up the first entry with the given id.
         S_FIND: begin
            if (idx_ff == cnt_ff) begin
               status_in = prqs_pkg::STAT_NOT_FOUND;  rsp_valid_in = 1'b1;  st_in = S_IDLE;
            end else if (rd_id == id_ff) begin
               case (op_ff)
                  prqs_pkg::ACT_DELETE: begin
                     if (cur_valid_ff && cur_id_ff == id_ff) cur_valid_in = 1'b0;
                     st_in = S_SHDN;
                  end
                  prqs_pkg::ACT_REQUEUE: begin
                     prio_in = rd_prio;  nst_in = rd_state;  jt_in = rd_join;  st_in = S_SHDN;
                  end
                  default: begin
                     wr_en = 1'b1;  wr_state = nst_ff;
                     if (nst_ff == prqs_pkg::THR_JOIN_WAIT) wr_join = jt_ff;
                     rsp_valid_in = 1'b1;  st_in = S_IDLE;
                  end
               endcase
            end else begin
               idx_in = CW'(idx_ff + CW'(1));
            end
         end
         // Close the gap by moving entries down one place.
         S_SHDN: begin
            if (CW'(idx_ff + CW'(1)) == cnt_ff) begin
               cnt_in = CW'(cnt_ff - CW'(1));
               if (op_ff == prqs_pkg::ACT_REQUEUE) begin
                  idx_in = '0;  st_in = S_POS;
               end else begin
                  rsp_valid_in = 1'b1;  st_in = S_IDLE;
               end
            end else begin
               wr_en = 1'b1;
               rd_addr = IW'(idx_ff + CW'(1));
               idx_in = CW'(idx_ff + CW'(1));
            end
         end
         // Walk in table order to the first ready entry.
         S_WALK: begin
            if (idx_ff == cnt_ff) begin
               rsp_valid_in = 1'b1;  st_in = S_IDLE;
            end else if (rd_state == prqs_pkg::THR_JOIN_WAIT) begin
               jt_in = rd_join;  aux_in = '0;  st_in = S_JSRCH;
            end else if (rd_state == prqs_pkg::THR_READY) begin
               pick_in = idx_ff;  aux_in = '0;
               st_in = cur_valid_ff ? S_CSRCH : S_SWITCH;
            end else begin
               idx_in = CW'(idx_ff + CW'(1));
            end
         end
         // Search for the join target; missing or exited releases the waiter.
         S_JSRCH: begin
            rd_addr = aux_ff[IW-1:0];
            if (aux_ff == cnt_ff) begin
               st_in = S_REL;
            end else if (rd_id == jt_ff) begin
               if (rd_state == prqs_pkg::THR_EXITED) begin
                  st_in = S_REL;
               end else begin
                  idx_in = CW'(idx_ff + CW'(1));  st_in = S_WALK;
               end
            end else begin
               aux_in = CW'(aux_ff + CW'(1));
            end
         end
         S_REL: begin
            wr_en = 1'b1;  wr_state = prqs_pkg::THR_READY;
            pick_in = idx_ff;  aux_in = '0;
            st_in = cur_valid_ff ? S_CSRCH : S_SWITCH;
         end
         // Locate the running thread in the table.
         S_CSRCH: begin
            rd_addr = aux_ff[IW-1:0];
            if (aux_ff == cnt_ff) begin
               st_in = S_SWITCH;
            end else if (rd_id == cur_id_ff) begin
               if (aux_ff == pick_ff) begin
                  rsp_valid_in = 1'b1;  st_in = S_IDLE;
               end else if (rd_state == prqs_pkg::THR_READY ||
                            rd_state == prqs_pkg::THR_RUNNING) begin
                  prio_in = rd_prio;  st_in = S_CCHK;
               end else begin
                  st_in = S_SWITCH;
               end
            end else begin
               aux_in = CW'(aux_ff + CW'(1));
            end
         end
         // Preemption test against the running thread and, with SRP enabled, the ceiling.
         S_CCHK: begin
            rd_addr = pick_ff[IW-1:0];
            if ((srp_ff && !({1'b0, rd_prio} < ceil_ff)) || !(prio_ff > rd_prio)) begin
               rsp_valid_in = 1'b1;  st_in = S_IDLE;
            end else begin
               st_in = S_DEMOTE;
            end
         end
         S_DEMOTE: begin
            rd_addr = aux_ff[IW-1:0];  wr_addr = aux_ff[IW-1:0];
            wr_en = 1'b1;  wr_state = prqs_pkg::THR_READY;  st_in = S_SWITCH;
         end
         S_SWITCH: begin
            rd_addr = pick_ff[IW-1:0];  wr_addr = pick_ff[IW-1:0];
            wr_en = 1'b1;  wr_state = prqs_pkg::THR_RUNNING;
            cur_valid_in = 1'b1;  cur_id_in = rd_id;  switched_in = 1'b1;
            rsp_valid_in = 1'b1;  st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;  cnt_ff <= '0;  srp_ff <= 1'b0;
         cur_valid_ff <= 1'b0;  cur_id_ff <= '0;  rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  cnt_ff <= cnt_in;  srp_ff <= srp_in;
         cur_valid_ff <= cur_valid_in;  cur_id_ff <= cur_id_in;  rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;  id_ff <= id_in;  prio_ff <= prio_in;  nst_ff <= nst_in;
      jt_ff <= jt_in;  ceil_ff <= ceil_in;  idx_ff <= idx_in;  aux_ff <= aux_in;
      pick_ff <= pick_in;  status_ff <= status_in;  switched_ff <= switched_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_switched      = switched_ff;
   assign rsp_running_valid = cur_valid_ff;
   assign rsp_running_id    = cur_valid_ff ? $signed(cur_id_ff) : '0;
   assign rsp_thread_count  = cnt_ff;

   // A result transfer only follows an accepted operation or a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept || busy))
      else $error("result without an operation");

   // The table never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_THREADS))
      else $error("thread count over capacity");

   // A reported switch always leaves a running thread.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switched) |-> rsp_running_valid)
      else $error("switch without running thread");

   // The count changes by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (cnt_ff == $past(cnt_ff) || cnt_ff == CW'($past(cnt_ff) + CW'(1)) ||
                cnt_ff == CW'($past(cnt_ff) - CW'(1))))
      else $error("thread count jumped");

endmodule

>>> tb/tb_priority_ready_queue_scheduler.sv
// Self-checking testbench for the priority ready queue scheduler.
`timescale 1ns / 100ps

module tb_priority_ready_queue_scheduler;

   localparam int unsigned SLOTS       = 16;
   localparam int unsigned DRAIN_WAIT  = 350;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam logic [2:0] THR_BLOCKED  = 3'd4;
   localparam logic [2:0] ACT_RESERVED = 3'd5;

   typedef struct packed {
      logic [1:0]  status;
      logic        switched;
      logic        running_valid;
      logic [15:0] running_id;
      logic [4:0]  thread_count;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_action = '0;
   logic signed [15:0] req_thread_id = '0;
   logic [7:0]         req_priority_req = '0;
   logic [2:0]         req_new_state = '0;
   logic signed [15:0] req_join_target_id = '0;
   logic [8:0]         req_system_ceiling = '0;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic               rsp_switched;
   logic               rsp_running_valid;
   logic signed [15:0] rsp_running_id;
   logic [4:0]         rsp_thread_count;

   priority_ready_queue_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_thread_id(req_thread_id),
      .req_priority_req(req_priority_req), .req_new_state(req_new_state),
      .req_join_target_id(req_join_target_id), .req_system_ceiling(req_system_ceiling),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_switched(rsp_switched),
      .rsp_running_valid(rsp_running_valid), .rsp_running_id(rsp_running_id),
      .rsp_thread_count(rsp_thread_count)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the ordered thread table and the running thread.
   logic [15:0] tbl_id [SLOTS];
   logic [7:0]  tbl_pri [SLOTS];
   logic [2:0]  tbl_st [SLOTS];
   logic [15:0] tbl_join [SLOTS];
   int          tbl_count = 0;
   bit          run_valid = 0;
   logic [15:0] run_id = '0;
   bit          srp_on = 0;

   outcome_type pending_outcomes[$];
   int       mismatches = 0;
   int       outcomes_seen = 0;
   int       ops_sent = 0;
   int       switches_seen = 0;
   int       full_seen = 0;
   int       cycles = 0;
   bit       no_idle = 0;

   function automatic int find_thread(input logic [15:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int slot_for(input logic [7:0] pri);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_pri[i] > pri) return i;
      return tbl_count;
   endfunction

   function automatic void remove_slot(input int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_id[i]   = tbl_id[i + 1];
         tbl_pri[i]  = tbl_pri[i + 1];
         tbl_st[i]   = tbl_st[i + 1];
         tbl_join[i] = tbl_join[i + 1];
      end
      tbl_count--;
   endfunction

   function automatic void insert_slot(input int pos, input logic [15:0] id,
                                       input logic [7:0] pri, input logic [2:0] st,
                                       input logic [15:0] jt);
      for (int i = tbl_count; i > pos; i--) begin
         tbl_id[i]   = tbl_id[i - 1];
         tbl_pri[i]  = tbl_pri[i - 1];
         tbl_st[i]   = tbl_st[i - 1];
         tbl_join[i] = tbl_join[i - 1];
      end
      tbl_id[pos]   = id;
      tbl_pri[pos]  = pri;
      tbl_st[pos]   = st;
      tbl_join[pos] = jt;
      tbl_count++;
   endfunction

   // Releases finished joins up to the first ready thread, then decides on preemption.
   function automatic void pick_next(input logic [8:0] ceil, output logic [1:0] stat,
                                     output logic sw);
      int pick;
      int cur;
      int t;
      pick = -1;
      sw = 1'b0;
      stat = prqs_pkg::STAT_DONE;
      if (tbl_count == 0) begin
         stat = prqs_pkg::STAT_NOT_FOUND;
         return;
      end
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_st[i] == prqs_pkg::THR_JOIN_WAIT) begin
            t = find_thread(tbl_join[i]);
            if (t < 0 || tbl_st[t] == prqs_pkg::THR_EXITED) tbl_st[i] = prqs_pkg::THR_READY;
         end
         if (tbl_st[i] == prqs_pkg::THR_READY) begin
            pick = i;
            break;
         end
      end
      if (pick < 0) return;
      cur = run_valid ? find_thread(run_id) : -1;
      if (cur == pick) return;
      if (cur >= 0 && (tbl_st[cur] == prqs_pkg::THR_READY ||
                       tbl_st[cur] == prqs_pkg::THR_RUNNING)) begin
         if (srp_on && !({1'b0, tbl_pri[pick]} < ceil)) return;
         if (!(tbl_pri[cur] > tbl_pri[pick])) return;
         tbl_st[cur] = prqs_pkg::THR_READY;
      end
      tbl_st[pick] = prqs_pkg::THR_RUNNING;
      run_valid = 1'b1;
      run_id = tbl_id[pick];
      sw = 1'b1;
   endfunction

   // Applies one operation to the shadow table and returns the expected outcome.
   function automatic outcome_type predict_op(input logic [2:0] act, input logic [15:0] id,
                                              input logic [7:0] pri, input logic [2:0] nst,
                                              input logic [15:0] jt, input logic [8:0] ceil);
      outcome_type o;
      int idx;
      logic [7:0] p;
      logic [2:0] s;
      logic [15:0] j;
      o = '0;
      o.status = prqs_pkg::STAT_DONE;
      case (act)
         prqs_pkg::ACT_ADD: begin
            if (tbl_count >= SLOTS) o.status = prqs_pkg::STAT_FULL;
            else insert_slot(slot_for(pri), id, pri, nst, jt);
         end
         prqs_pkg::ACT_DELETE, prqs_pkg::ACT_REQUEUE, prqs_pkg::ACT_SETSTATE: begin
            idx = find_thread(id);
            if (idx < 0) begin
               o.status = prqs_pkg::STAT_NOT_FOUND;
            end else if (act == prqs_pkg::ACT_DELETE) begin
               if (run_valid && run_id == id) run_valid = 1'b0;
               remove_slot(idx);
            end else if (act == prqs_pkg::ACT_REQUEUE) begin
               p = tbl_pri[idx];
               s = tbl_st[idx];
               j = tbl_join[idx];
               remove_slot(idx);
               insert_slot(slot_for(p), id, p, s, j);
            end else begin
               tbl_st[idx] = nst;
               if (nst == prqs_pkg::THR_JOIN_WAIT) tbl_join[idx] = jt;
            end
         end
         prqs_pkg::ACT_SCHEDULE: pick_next(ceil, o.status, o.switched);
         default: ;
      endcase
      o.running_valid = run_valid;
      o.running_id = run_valid ? run_id : 16'd0;
      o.thread_count = tbl_count[4:0];
      return o;
   endfunction

   // Sends one operation, predicts it at the transfer, then idles a random gap.
   task automatic send_op(input logic [2:0] act, input logic [15:0] id,
                          input logic [7:0] pri, input logic [2:0] nst,
                          input logic [15:0] jt, input logic [8:0] ceil);
      int gap;
      start <= 1'b1;
      req_action <= act;
      req_thread_id <= id;
      req_priority_req <= pri;
      req_new_state <= nst;
      req_join_target_id <= jt;
      req_system_ceiling <= ceil;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(predict_op(act, id, pri, nst, jt, ceil));
      ops_sent++;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every outcome, lets the block settle, then writes the SRP enable.
   task automatic set_srp(input bit value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      srp_on = value;
   endtask

   // Compares each result with the oldest expected outcome.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_switched, rsp_running_valid, rsp_running_id, rsp_thread_count};
         outcomes_seen++;
         if (rsp_switched) switches_seen++;
         if (rsp_status == prqs_pkg::STAT_FULL) full_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: %p", got);
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result %0d differs: expected %p, got %p", outcomes_seen, want, got);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_empty_table();
      send_op(prqs_pkg::ACT_SCHEDULE, 16'h0001, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd256);
      send_op(prqs_pkg::ACT_DELETE, 16'h0001, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_REQUEUE, 16'h0002, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_SETSTATE, 16'h0003, 8'd0, prqs_pkg::THR_EXITED, 16'h0000, 9'd0);
   endtask

   // Fills the table to the limit with extreme ids and priorities, then overfills it.
   task automatic test_fill_and_extremes();
      send_op(prqs_pkg::ACT_ADD, 16'h8000, 8'd255, prqs_pkg::THR_READY, 16'hFFFF, 9'd0);
      send_op(prqs_pkg::ACT_ADD, 16'h7FFF, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_SCHEDULE, 16'h0000, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      for (int i = 0; i < 14; i++)
         send_op(prqs_pkg::ACT_ADD, 16'(i), 8'(i % 3 + 1), 3'(i % 8), 16'h7FFF, 9'd0);
      send_op(prqs_pkg::ACT_ADD, 16'hFFFF, 8'd1, THR_BLOCKED, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_DELETE, 16'h7FFF, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_REQUEUE, 16'h0000, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_DELETE, 16'h1234, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
   endtask

   // Join waits on exited and missing targets, the ceiling test, reserved actions.
   task automatic test_join_ceiling_reserved();
      send_op(prqs_pkg::ACT_SETSTATE, 16'h0001, 8'd0, prqs_pkg::THR_JOIN_WAIT, 16'h0002, 9'd0);
      send_op(prqs_pkg::ACT_SETSTATE, 16'h0002, 8'd0, prqs_pkg::THR_EXITED, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_SETSTATE, 16'h0004, 8'd0, prqs_pkg::THR_JOIN_WAIT, 16'h5555, 9'd0);
      send_op(prqs_pkg::ACT_SCHEDULE, 16'h0000, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
      send_op(prqs_pkg::ACT_SCHEDULE, 16'h0000, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd511);
      for (int k = 0; k < 3; k++)
         send_op(ACT_RESERVED + 3'(k), 16'h0001, 8'd0, prqs_pkg::THR_READY, 16'h0000, 9'd0);
   endtask

   function automatic logic [15:0] pick_id();
      if (tbl_count > 0 && $urandom_range(0, 9) < 8)
         return tbl_id[$urandom_range(0, tbl_count - 1)];
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
   endfunction

   // Random operations aimed mostly at threads in the table.
   task automatic test_random_ops(input int n);
      int sel;
      logic [2:0] act;
      logic [2:0] st;
      logic [7:0] pri;
      logic [8:0] ceil;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 2) act = ACT_RESERVED + 3'($urandom_range(0, 2));
         else if (sel < 30 - tbl_count) act = prqs_pkg::ACT_ADD;
         else if (sel < 40) act = prqs_pkg::ACT_DELETE;
         else if (sel < 50) act = prqs_pkg::ACT_REQUEUE;
         else if (sel < 72) act = prqs_pkg::ACT_SETSTATE;
         else act = prqs_pkg::ACT_SCHEDULE;
         st = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
         pri = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
         ceil = ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'($urandom_range(0, 9));
         send_op(act, pick_id(), pri, st, pick_id(), ceil);
      end
      no_idle = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_srp(1'b0);
      test_empty_table();
      test_fill_and_extremes();
      set_srp(1'b1);
      test_join_ceiling_reserved();
      test_random_ops(400);
      set_srp(1'b0);
      test_random_ops(400);
      set_srp(1'b1);
      test_random_ops(420);
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Ran %0d operations with SRP off and on; %0d results checked,", ops_sent,
               outcomes_seen);
      $display("%0d thread switches and %0d full-table rejects seen.", switches_seen,
               full_seen);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
